// ===== rtl/core/pcvb_pkg.sv =====
package pcvb_pkg;

   localparam int GRID_X     = 512;
   localparam int GRID_Y     = 512;
   localparam int GRID_Z     = 1;
   localparam int VOXEL_CAP  = 16384;
   localparam int MAX_POINTS = 64;

   localparam int NUM_CELLS = GRID_X * GRID_Y * GRID_Z;
   localparam int CELL_AW   = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int VOX_AW    = (VOXEL_CAP > 1) ? $clog2(VOXEL_CAP) : 1;

   localparam int COORD_W    = 20;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int INV_W      = 16;
   localparam int PROD_W     = DIFF_W + INV_W + 1;
   localparam int FRAC_W     = 16;
   localparam int CELLQ_W    = PROD_W - FRAC_W;
   localparam int VLIM_W     = 15;
   localparam int PLIM_W     = 7;
   localparam int CX_W       = 9;
   localparam int CY_W       = 9;
   localparam int CZ_W       = 4;
   localparam int VIDX_W     = 14;
   localparam int SLOT_W     = 6;
   localparam int TOTAL_W    = 15;
   localparam int FILL_W     = 7;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [STATUS_W-1:0] {
      ST_EXISTING = 3'd0,
      ST_NEW      = 3'd1,
      ST_RANGE    = 3'd2,
      ST_FULL     = 3'd3,
      ST_LIMIT    = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ORIGIN_X     = 3'd0,
      REG_ORIGIN_Y     = 3'd1,
      REG_ORIGIN_Z     = 3'd2,
      REG_INV_SIZE_X   = 3'd3,
      REG_INV_SIZE_Y   = 3'd4,
      REG_INV_SIZE_Z   = 3'd5,
      REG_VOXEL_LIMIT  = 3'd6,
      REG_POINTS_LIMIT = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
      logic [INV_W-1:0]          inv_size_x;
      logic [INV_W-1:0]          inv_size_y;
      logic [INV_W-1:0]          inv_size_z;
      logic [VLIM_W-1:0]         voxel_limit;
      logic [PLIM_W-1:0]         points_limit;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      origin_x:     20'sd0,
      origin_y:     -20'sd10158,
      origin_z:     -20'sd768,
      inv_size_x:   16'd1600,
      inv_size_y:   16'd1600,
      inv_size_z:   16'd64,
      voxel_limit:  15'd12000,
      points_limit: 7'd32
   };

   // classified point as handed from front to back
   typedef struct packed {
      logic               first;
      logic               on_grid;
      logic [CX_W-1:0]    cx;
      logic [CY_W-1:0]    cy;
      logic [CZ_W-1:0]    cz;
      logic [CELL_AW-1:0] addr;
   } entry_type;

   typedef struct packed {
      status_type         status;
      logic [VIDX_W-1:0]  voxel_index;
      logic [SLOT_W-1:0]  point_slot;
      logic [CX_W-1:0]    cell_x;
      logic [CY_W-1:0]    cell_y;
      logic [CZ_W-1:0]    cell_z;
      logic [TOTAL_W-1:0] voxels_used;
   } result_type;

endpackage

// ===== rtl/core/pcvb_ram.sv =====
module pcvb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pcvb_front.sv =====
module pcvb_front (
   input  logic                            clock,
   input  logic                            reset,
   input  pcvb_pkg::cfg_type               cfg,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic                            in_first,
   input  logic signed [pcvb_pkg::COORD_W-1:0] in_x,
   input  logic signed [pcvb_pkg::COORD_W-1:0] in_y,
   input  logic signed [pcvb_pkg::COORD_W-1:0] in_z,
   output logic                            out_valid,
   input  logic                            out_ready,
   output pcvb_pkg::entry_type             out_entry
);
   import pcvb_pkg::*;

   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_first_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, dz_ff;
   logic                     s2_valid_ff, s2_valid_in;
   logic                     s2_first_ff;
   logic signed [PROD_W-1:0] px_ff, py_ff, pz_ff;
   logic signed [PROD_W-1:0] px_in, py_in, pz_in;
   logic                     advance;
   logic [CELLQ_W-1:0]       qx, qy, qz;
   logic                     ok_x, ok_y, ok_z;

   assign advance  = !(s2_valid_ff && !out_ready);
   assign in_ready = advance;

   always_comb begin
      s1_valid_in = advance ? in_valid : s1_valid_ff;
      s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;
      px_in = dx_ff * $signed({1'b0, cfg.inv_size_x});
      py_in = dy_ff * $signed({1'b0, cfg.inv_size_y});
      pz_in = dz_ff * $signed({1'b0, cfg.inv_size_z});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (advance) begin
         s1_first_ff <= in_first;
         dx_ff <= DIFF_W'(in_x) - DIFF_W'(cfg.origin_x);
         dy_ff <= DIFF_W'(in_y) - DIFF_W'(cfg.origin_y);
         dz_ff <= DIFF_W'(in_z) - DIFF_W'(cfg.origin_z);
         s2_first_ff <= s1_first_ff;
         px_ff <= px_in;
         py_ff <= py_in;
         pz_ff <= pz_in;
      end
   end

   // arithmetic shift by the fraction width is an exact floor
   assign qx = px_ff[PROD_W-1:FRAC_W];
   assign qy = py_ff[PROD_W-1:FRAC_W];
   assign qz = pz_ff[PROD_W-1:FRAC_W];

   assign ok_x = !qx[CELLQ_W-1] && (qx < CELLQ_W'(GRID_X));
   assign ok_y = !qy[CELLQ_W-1] && (qy < CELLQ_W'(GRID_Y));
   assign ok_z = !qz[CELLQ_W-1] && (qz < CELLQ_W'(GRID_Z));

   always_comb begin
      out_entry.first    = s2_first_ff;
      out_entry.on_grid  = ok_x && ok_y && ok_z;
      out_entry.cx       = qx[CX_W-1:0];
      out_entry.cy       = qy[CY_W-1:0];
      out_entry.cz       = qz[CZ_W-1:0];
      out_entry.addr     = CELL_AW'(qz[CZ_W-1:0])
                         + CELL_AW'(qy[CY_W-1:0]) * CELL_AW'(GRID_Z)
                         + CELL_AW'(qx[CX_W-1:0]) * CELL_AW'(GRID_Y * GRID_Z);
   end

   assign out_valid = s2_valid_ff;

endmodule

// ===== rtl/core/pcvb_queue.sv =====
module pcvb_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  pcvb_pkg::entry_type push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output pcvb_pkg::entry_type pop_entry
);
   import pcvb_pkg::*;

   entry_type             slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_entry  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/pcvb_back.sv =====
module pcvb_back (
   input  logic                 clock,
   input  logic                 reset,
   input  pcvb_pkg::cfg_type    cfg,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  pcvb_pkg::entry_type  q_entry,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pcvb_pkg::result_type rsp
);
   import pcvb_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK1,
      S_LOOK2,
      S_OUT
   } state_type;

   state_type          state_ff, state_in;
   entry_type          ent_ff, ent_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               full_ff, full_in;
   logic               valid_ff, valid_in;
   result_type         res_ff, res_in;

   logic [TOTAL_W-1:0] total_start;
   logic               full_start;
   logic [TOTAL_W-1:0] vlim;
   logic [FILL_W-1:0]  plim;

   logic [VOX_AW-1:0]  c2v_rdata;
   logic [CELL_AW-1:0] vca_rdata;
   logic [FILL_W-1:0]  fill_rdata;

   logic               hit, open_new;
   logic [VOX_AW-1:0]  vidx;
   logic [FILL_W-1:0]  fill_cur;
   logic               fits;

   logic               c2v_we, vca_we, fill_we;
   logic [FILL_W-1:0]  fill_wdata;

   assign vlim = (TOTAL_W'(cfg.voxel_limit) > TOTAL_W'(VOXEL_CAP))
               ? TOTAL_W'(VOXEL_CAP) : TOTAL_W'(cfg.voxel_limit);
   assign plim = (FILL_W'(cfg.points_limit) > FILL_W'(MAX_POINTS))
               ? FILL_W'(MAX_POINTS) : FILL_W'(cfg.points_limit);

   assign q_ready = (state_ff == S_IDLE);

   assign total_start = q_entry.first ? '0 : total_ff;
   assign full_start  = q_entry.first ? 1'b0 : full_ff;

   // a table entry counts only if it names a voxel of this frame that owns the cell
   assign hit      = (TOTAL_W'(c2v_rdata) < total_ff) && (vca_rdata == ent_ff.addr);
   assign open_new = !hit && (total_ff < vlim);
   assign vidx     = hit ? c2v_rdata : total_ff[VOX_AW-1:0];
   assign fill_cur = hit ? fill_rdata : '0;
   assign fits     = (fill_cur < plim);

   assign c2v_we     = (state_ff == S_LOOK2) && open_new;
   assign vca_we     = c2v_we;
   assign fill_we    = (state_ff == S_LOOK2) && (hit || open_new);
   assign fill_wdata = fits ? fill_cur + 1'b1 : fill_cur;

   pcvb_ram #(.WIDTH(VOX_AW), .DEPTH(NUM_CELLS)) u_cell_to_voxel (
      .clock   (clock),
      .wr_en   (c2v_we),
      .wr_addr (ent_ff.addr),
      .wr_data (total_ff[VOX_AW-1:0]),
      .rd_en   ((state_ff == S_IDLE) && q_valid),
      .rd_addr (q_entry.addr),
      .rd_data (c2v_rdata)
   );

   pcvb_ram #(.WIDTH(CELL_AW), .DEPTH(VOXEL_CAP)) u_voxel_cell_addr (
      .clock   (clock),
      .wr_en   (vca_we),
      .wr_addr (total_ff[VOX_AW-1:0]),
      .wr_data (ent_ff.addr),
      .rd_en   (state_ff == S_LOOK1),
      .rd_addr (c2v_rdata),
      .rd_data (vca_rdata)
   );

   pcvb_ram #(.WIDTH(FILL_W), .DEPTH(VOXEL_CAP)) u_voxel_fill (
      .clock   (clock),
      .wr_en   (fill_we),
      .wr_addr (vidx),
      .wr_data (fill_wdata),
      .rd_en   (state_ff == S_LOOK1),
      .rd_addr (c2v_rdata),
      .rd_data (fill_rdata)
   );

   always_comb begin
      state_in = state_ff;
      ent_in   = ent_ff;
      total_in = total_ff;
      full_in  = full_ff;
      valid_in = valid_ff;
      res_in   = res_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               ent_in   = q_entry;
               total_in = total_start;
               full_in  = full_start;
               res_in   = '0;
               res_in.voxels_used = total_start;
               if (full_start) begin
                  res_in.status = ST_FULL;
                  valid_in      = 1'b1;
                  state_in      = S_OUT;
               end else if (!q_entry.on_grid) begin
                  res_in.status = ST_RANGE;
                  valid_in      = 1'b1;
                  state_in      = S_OUT;
               end else begin
                  state_in = S_LOOK1;
               end
            end
         end
         S_LOOK1: begin
            state_in = S_LOOK2;
         end
         S_LOOK2: begin
            res_in = '0;
            if (!hit && !open_new) begin
               full_in = 1'b1;
               res_in.status      = ST_FULL;
               res_in.voxels_used = total_ff;
            end else begin
               res_in.status      = hit ? ST_EXISTING : ST_NEW;
               res_in.voxel_index = VIDX_W'(vidx);
               res_in.cell_x      = ent_ff.cx;
               res_in.cell_y      = ent_ff.cy;
               res_in.cell_z      = ent_ff.cz;
               if (open_new) begin
                  total_in = total_ff + 1'b1;
               end
               res_in.voxels_used = open_new ? total_ff + 1'b1 : total_ff;
               if (fits) begin
                  res_in.point_slot = fill_cur[SLOT_W-1:0];
               end else begin
                  res_in.status = ST_LIMIT;
               end
            end
            valid_in = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               valid_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
            valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= '0;
         full_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         full_ff  <= full_in;
         valid_ff <= valid_in;
      end
      ent_ff <= ent_in;
      res_ff <= res_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = res_ff;

endmodule

// ===== rtl/core/point_cloud_voxel_binner_unit.sv =====
// channel   dir  handshake               payload
// req       in   req_tvalid/req_tready   tuser: first_of_frame; tdata: point x, y, z
// rsp       out  rsp_tvalid/rsp_tready   tuser: status; tdata: voxel, slot, cells, count
// csr       in   csr_we                  csr_index, csr_wdata
//
// The front takes a point every cycle unless its output stalls, into a two-stage
// subtract/multiply pipe, range checks its output and pushes it into a four-entry queue.
// The back handles one point at a time. In-grid: cell table read, voxel record read,
// update, result, set by the chain of registered table reads. Off-grid or full frame:
// straight to result. The result step repeats while rsp_tready is low.
// Reset is synchronous and needs no table sweep: lookups are checked against the
// frame's voxel count. A stalled rsp backs up into the queue, then into req_tready.
module point_cloud_voxel_binner_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // point_x[19:0], point_y[39:20], point_z[59:40], zeros
   input  logic [0:0]  req_tuser,  // first_of_frame[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // voxel_index[13:0], point_slot[19:14], cell_x[28:20],
                                   // cell_y[37:29], cell_z[41:38], voxels_used[56:42], zeros
   output logic [2:0]  rsp_tuser,  // status[2:0]
   input  logic        csr_we,
   input  logic [pcvb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pcvb_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pcvb_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       f_valid, f_ready;
   entry_type  f_entry;
   logic       q_valid, q_ready;
   entry_type  q_entry;
   result_type res;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_ORIGIN_X:     cfg_in.origin_x     = csr_wdata[COORD_W-1:0];
            REG_ORIGIN_Y:     cfg_in.origin_y     = csr_wdata[COORD_W-1:0];
            REG_ORIGIN_Z:     cfg_in.origin_z     = csr_wdata[COORD_W-1:0];
            REG_INV_SIZE_X:   cfg_in.inv_size_x   = csr_wdata[INV_W-1:0];
            REG_INV_SIZE_Y:   cfg_in.inv_size_y   = csr_wdata[INV_W-1:0];
            REG_INV_SIZE_Z:   cfg_in.inv_size_z   = csr_wdata[INV_W-1:0];
            REG_VOXEL_LIMIT:  cfg_in.voxel_limit  = csr_wdata[VLIM_W-1:0];
            REG_POINTS_LIMIT: cfg_in.points_limit = csr_wdata[PLIM_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pcvb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_first  (req_tuser[0]),
      .in_x      (req_tdata[19:0]),
      .in_y      (req_tdata[39:20]),
      .in_z      (req_tdata[59:40]),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_entry (f_entry)
   );

   pcvb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_entry (f_entry),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_entry  (q_entry)
   );

   pcvb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_entry   (q_entry),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (res)
   );

   assign rsp_tuser = res.status;
   assign rsp_tdata = {7'd0, res.voxels_used, res.cell_z, res.cell_y, res.cell_x,
                       res.point_slot, res.voxel_index};

endmodule
